### rtl/core/emrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Eller maze row generator package
// Shared widths, label ring commands and status for the row generator.
// ----------------------------------------------------------------------------
package emrg_pkg;

   localparam int LABEL_W    = 6;     // set label width, 0 means empty
   localparam int NUM_LABELS = 64;
   localparam int COL_W      = 6;     // column count, 1..32
   localparam int ROW_W      = 10;    // row index
   localparam int ROWS_W     = 11;    // row count, 1..1024
   localparam int MAX_ROWS   = 1024;
   localparam int RCOIN_W    = 31;
   localparam int WALL_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_COLS = 2'd1;

   // operations of the label ring
   typedef enum logic [3:0] {
      ROP_HOLD   = 4'd0,   // no change
      ROP_CLEAR  = 4'd1,   // empty unused columns, reset used mask and bottom bits
      ROP_USED   = 4'd2,   // record label of head column
      ROP_FILL   = 4'd3,   // give head column a fresh label if empty
      ROP_RIGHT  = 4'd4,   // right wall decision, merge on open wall
      ROP_LAST   = 4'd5,   // last row: merge every differing neighbor
      ROP_COUNT  = 4'd6,   // bottom wall from coin and set size
      ROP_OPEN   = 4'd7,   // reopen leftmost cell of a fully walled set
      ROP_FINISH = 4'd8,   // empty cells under a bottom wall
      ROP_WIPE   = 4'd9    // empty all cells
   } ring_op_type;

   typedef struct packed {
      ring_op_type op;
      logic        act;    // head column takes part in this step
      logic        coin;   // coin bit of the head column
   } ring_cmd_type;

   typedef struct packed {
      logic eq;            // head column and its right neighbor share a set
   } ring_stat_type;

endpackage
`default_nettype wire

### rtl/core/emrg_label_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Eller maze label ring
// Circular store of per-column set labels and bottom wall bits. Each pass
// rotates the ring by one column per cycle so the column in work always sits
// at position 0; relabel and set searches compare all positions in parallel.
// ----------------------------------------------------------------------------
module emrg_label_ring #(
   parameter int MAX_COLS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  emrg_pkg::ring_cmd_type      cmd,
   input  logic [emrg_pkg::COL_W-1:0]  ncols,
   output emrg_pkg::ring_stat_type     stat,
   output logic [MAX_COLS-1:0]         bw_bits
);

   import emrg_pkg::*;

   logic [LABEL_W-1:0]    lab_ff [MAX_COLS];
   logic [LABEL_W-1:0]    lab_in [MAX_COLS];
   logic [MAX_COLS-1:0]   bwr_ff, bwr_in;
   logic [NUM_LABELS-1:0] used_ff, used_in;

   logic [LABEL_W-1:0] head, nxt, free_lab;
   logic               eq, multi, open, merge;

   assign head    = lab_ff[0];
   assign nxt     = lab_ff[1];
   assign eq      = (head == nxt);
   assign stat.eq = eq;
   assign bw_bits = bwr_ff;

   assign merge = cmd.act && !eq &&
                  ((cmd.op == ROP_LAST) || ((cmd.op == ROP_RIGHT) && !cmd.coin));

   // smallest label not in use, 63 if all others taken
   always_comb begin
      free_lab = LABEL_W'(NUM_LABELS - 1);
      for (int l = NUM_LABELS - 2; l >= 1; l--) begin
         if (!used_ff[l]) free_lab = LABEL_W'(l);
      end
   end

   always_comb begin
      multi = 1'b0;
      open  = 1'b0;
      for (int k = 0; k < MAX_COLS; k++) begin
         if (k != 0 && lab_ff[k] == head) multi = 1'b1;
         if (lab_ff[k] == head && !bwr_ff[k]) open = 1'b1;
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_COLS; k++) lab_in[k] = lab_ff[k];
      bwr_in  = bwr_ff;
      used_in = used_ff;
      unique case (cmd.op)
         ROP_HOLD: begin
         end
         ROP_CLEAR: begin
            for (int k = 0; k < MAX_COLS; k++) begin
               if (COL_W'(k) >= ncols) lab_in[k] = '0;
            end
            used_in = NUM_LABELS'(1);
            bwr_in  = '0;
         end
         ROP_USED: begin
            for (int k = 0; k < MAX_COLS; k++) lab_in[k] = lab_ff[(k + 1) % MAX_COLS];
            if (cmd.act) used_in[head] = 1'b1;
         end
         ROP_FILL: begin
            for (int k = 0; k < MAX_COLS; k++) lab_in[k] = lab_ff[(k + 1) % MAX_COLS];
            if (cmd.act && head == '0) begin
               lab_in[MAX_COLS-1] = free_lab;
               used_in[free_lab]  = 1'b1;
            end
         end
         ROP_RIGHT, ROP_LAST: begin
            for (int k = 0; k < MAX_COLS; k++) begin
               if (merge && lab_ff[(k + 1) % MAX_COLS] == nxt) lab_in[k] = head;
               else lab_in[k] = lab_ff[(k + 1) % MAX_COLS];
            end
         end
         ROP_COUNT: begin
            for (int k = 0; k < MAX_COLS; k++) lab_in[k] = lab_ff[(k + 1) % MAX_COLS];
            bwr_in = {cmd.act && cmd.coin && multi, bwr_ff[MAX_COLS-1:1]};
         end
         ROP_OPEN: begin
            // bits already decided this pass count, so only the leftmost reopens
            for (int k = 0; k < MAX_COLS; k++) lab_in[k] = lab_ff[(k + 1) % MAX_COLS];
            bwr_in = {bwr_ff[0] && open, bwr_ff[MAX_COLS-1:1]};
         end
         ROP_FINISH: begin
            for (int k = 0; k < MAX_COLS; k++) begin
               if (bwr_ff[k]) lab_in[k] = '0;
            end
         end
         ROP_WIPE: begin
            for (int k = 0; k < MAX_COLS; k++) lab_in[k] = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_COLS; k++) lab_ff[k] <= '0;
      end else begin
         for (int k = 0; k < MAX_COLS; k++) lab_ff[k] <= lab_in[k];
      end
   end

   always_ff @(posedge clock) begin
      bwr_ff  <= bwr_in;
      used_ff <= used_in;
   end

endmodule
`default_nettype wire

### rtl/core/eller_maze_row_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Eller maze row generator
// Generates one row of a perfect maze per request from random coin bits,
// keeping per-column set labels and the row counter between requests.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   right_coins, down_coins
//   rsp_      out        rsp_valid / rsp_stall   right/bottom wall bits, row, done
//   csr_      in         csr_wr_en               csr_index, csr_wdata
//
// A row takes the label ring through used, fill, right wall and two bottom
// wall passes (one merge pass on the last row); the ring makes one full
// rotation per pass, one column per cycle.
// Reset is synchronous and clears labels, row counter and control state.
// A new request is taken while a result still waits on rsp_stall; the
// following result waits in the output state until the slot is free.
// ----------------------------------------------------------------------------
module eller_maze_row_generator_top #(
   parameter int MAX_COLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [emrg_pkg::RCOIN_W-1:0]        req_right_coins,
   input  logic [emrg_pkg::WALL_W-1:0]         req_down_coins,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [emrg_pkg::WALL_W-1:0]         rsp_right_wall_bits,
   output logic [emrg_pkg::WALL_W-1:0]         rsp_bottom_wall_bits,
   output logic [emrg_pkg::ROW_W-1:0]          rsp_row_number,
   output logic                                rsp_maze_done,
   input  logic                                csr_wr_en,
   input  logic [emrg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [emrg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import emrg_pkg::*;

   localparam int CW = $clog2(MAX_COLS);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_USED  = 9'b000000010,
      ST_FILL  = 9'b000000100,
      ST_RIGHT = 9'b000001000,
      ST_LAST  = 9'b000010000,
      ST_COUNT = 9'b000100000,
      ST_OPEN  = 9'b001000000,
      ST_FIN   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [ROWS_W-1:0]   rows_ff;
   logic [COL_W-1:0]    cols_ff;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                last_ff, last_in;
   logic [MAX_COLS-1:0] rc_ff, rc_in, dc_ff, dc_in, rw_ff, rw_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [WALL_W-1:0]   rsp_rw_ff, rsp_rw_in, rsp_bw_ff, rsp_bw_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [COL_W-1:0]    ncols, col6;
   logic [ROWS_W-1:0]   nrows;
   logic                last_now, col_last, act_col, act_pair, req_xfer, load;
   logic [MAX_COLS-1:0] col_mask, bw_bits;
   ring_cmd_type        cmd;
   ring_stat_type       stat;

   // column and row counts clamped to their legal ranges
   always_comb begin
      if (cols_ff == '0) ncols = COL_W'(1);
      else if (cols_ff > COL_W'(MAX_COLS)) ncols = COL_W'(MAX_COLS);
      else ncols = cols_ff;
      if (rows_ff == '0) nrows = ROWS_W'(1);
      else if (rows_ff > ROWS_W'(MAX_ROWS)) nrows = ROWS_W'(MAX_ROWS);
      else nrows = rows_ff;
      for (int k = 0; k < MAX_COLS; k++) col_mask[k] = (COL_W'(k) < ncols);
   end

   assign last_now  = (ROWS_W'(row_ff) + ROWS_W'(1)) >= nrows;
   assign col6      = COL_W'(col_ff);
   assign col_last  = (col_ff == CW'(MAX_COLS - 1));
   assign act_col   = (col6 < ncols);
   assign act_pair  = ((col6 + COL_W'(1)) < ncols);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign load      = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   emrg_label_ring #(
      .MAX_COLS (MAX_COLS)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .ncols   (ncols),
      .stat    (stat),
      .bw_bits (bw_bits)
   );

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      last_in     = last_ff;
      rc_in       = rc_ff;
      dc_in       = dc_ff;
      rw_in       = rw_ff;
      cmd.op      = ROP_HOLD;
      cmd.act     = 1'b0;
      cmd.coin    = 1'b0;
      rsp_rw_in   = rsp_rw_ff;
      rsp_bw_in   = rsp_bw_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_done_in = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (state_ff != ST_IDLE && state_ff != ST_FIN && state_ff != ST_OUT) begin
         col_in = col_last ? '0 : col_ff + CW'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd.op   = ROP_CLEAR;
               col_in   = '0;
               rc_in    = MAX_COLS'(req_right_coins);
               dc_in    = MAX_COLS'(req_down_coins);
               last_in  = last_now;
               rw_in    = '0;
               state_in = ST_USED;
            end
         end
         ST_USED: begin
            cmd.op  = ROP_USED;
            cmd.act = act_col;
            if (col_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.op  = ROP_FILL;
            cmd.act = act_col;
            if (col_last) state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            cmd.op   = ROP_RIGHT;
            cmd.act  = act_pair;
            cmd.coin = rc_ff[col_ff];
            // rightmost used column is always walled
            rw_in[col_ff] = act_pair ? (rc_ff[col_ff] || stat.eq)
                                     : (col6 == ncols - COL_W'(1));
            if (col_last) state_in = last_ff ? ST_LAST : ST_COUNT;
         end
         ST_LAST: begin
            cmd.op  = ROP_LAST;
            cmd.act = act_pair;
            if (act_pair && !stat.eq) rw_in[col_ff] = 1'b0;
            if (col_last) state_in = ST_FIN;
         end
         ST_COUNT: begin
            cmd.op   = ROP_COUNT;
            cmd.act  = act_col;
            cmd.coin = dc_ff[col_ff];
            if (col_last) state_in = ST_OPEN;
         end
         ST_OPEN: begin
            cmd.op  = ROP_OPEN;
            cmd.act = act_col;
            if (col_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = last_ff ? ROP_WIPE : ROP_FINISH;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_rw_in    = WALL_W'(rw_ff);
               rsp_bw_in    = last_ff ? WALL_W'(col_mask) : WALL_W'(bw_bits);
               rsp_row_in   = row_ff;
               rsp_done_in  = last_ff;
               row_in       = last_ff ? '0 : row_ff + ROW_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= ROWS_W'(16);
         cols_ff      <= COL_W'(16);
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == CSR_MAZE_ROWS) rows_ff <= csr_wdata[ROWS_W-1:0];
         if (csr_wr_en && csr_index == CSR_MAZE_COLS) cols_ff <= csr_wdata[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rc_ff       <= rc_in;
      dc_ff       <= dc_in;
      rw_ff       <= rw_in;
      rsp_rw_ff   <= rsp_rw_in;
      rsp_bw_ff   <= rsp_bw_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_right_wall_bits  = rsp_rw_ff;
   assign rsp_bottom_wall_bits = rsp_bw_ff;
   assign rsp_row_number       = rsp_row_ff;
   assign rsp_maze_done        = rsp_done_ff;

endmodule
`default_nettype wire
